/* src/lems_pkg.sv */
// Shared types, constants and colour tables for the LED effect mode sequencer.
// Used by lems_alu, lems_effects and led_effect_mode_sequencer; depends on nothing.
`timescale 1ns / 1ps

package lems_pkg;

    localparam int LED_COUNT   = 6;
    localparam int HUES        = 6;
    localparam int CNT_W       = 10;
    localparam int WAIT_W      = 16;
    localparam int TIME_W      = 32;
    localparam int IDX_W       = 3;
    localparam int MODE_W      = 2;
    localparam int CFG_ADDR_W  = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int S_DATA_W    = 40;
    localparam int M_DATA_W    = 32;

    localparam logic [CNT_W-1:0]  CNT_MAX       = 10'd1023;
    localparam logic [CNT_W-1:0]  THR_RESET     = 10'd500;
    localparam logic [WAIT_W-1:0] FADE_RESET    = 16'd10;
    localparam logic [WAIT_W-1:0] CHASE_RESET   = 16'd200;
    localparam logic [WAIT_W-1:0] BREATHE_RESET = 16'd10;
    localparam logic [WAIT_W-1:0] ROTATE_RESET  = 16'd500;
    localparam logic [IDX_W-1:0]  LAST_LED      = 3'(LED_COUNT - 1);

    localparam logic [CFG_ADDR_W-1:0] REG_DEBOUNCE = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_FADE     = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_CHASE    = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_BREATHE  = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_ROTATE   = 3'd4;

    localparam logic [MODE_W-1:0] MODE_FADE    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_CHASE   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_BREATHE = 2'd2;
    localparam logic [MODE_W-1:0] MODE_ROTATE  = 2'd3;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_t;

    typedef struct packed {
        logic              prep;
        logic              adv;
        logic [MODE_W-1:0] mode;
        logic [IDX_W-1:0]  pix_idx;
    } effect_ctrl_t;

    function automatic rgb_t chase_colour(input logic [IDX_W-1:0] i);
        rgb_t c;
        unique case (i)
            3'd0:    c = '{8'd0,   8'd0,   8'd255};
            3'd1:    c = '{8'd128, 8'd0,   8'd128};
            3'd2:    c = '{8'd255, 8'd0,   8'd0};
            3'd3:    c = '{8'd128, 8'd128, 8'd0};
            3'd4:    c = '{8'd0,   8'd255, 8'd0};
            3'd5:    c = '{8'd0,   8'd128, 8'd128};
            default: c = '0;
        endcase
        return c;
    endfunction

    function automatic rgb_t rotate_colour(input logic [IDX_W-1:0] i);
        rgb_t c;
        unique case (i)
            3'd0:    c = '{8'd0,   8'd255, 8'd0};
            3'd1:    c = '{8'd255, 8'd0,   8'd0};
            3'd2:    c = '{8'd0,   8'd0,   8'd255};
            3'd3:    c = '{8'd128, 8'd128, 8'd0};
            3'd4:    c = '{8'd128, 8'd0,   8'd128};
            3'd5:    c = '{8'd255, 8'd128, 8'd0};
            default: c = '0;
        endcase
        return c;
    endfunction

endpackage

/* src/led_effect_mode_sequencer.sv */
// LED effect mode sequencer top level; depends on lems_pkg, lems_alu and lems_effects.
// A poll is accepted only in the idle state and then passes through the count, debounce,
// difference and compare states, the last three using the shared subtractor; a poll that
// does not fire then returns to idle. A firing poll emits its LED items, one item a cycle
// while the output is not stalled, and then steps the effect in the advance state.
// Reset (aresetn low, synchronous) restores the register defaults and all effect state.
`timescale 1ns / 1ps

module led_effect_mode_sequencer (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // From bit 0: button_low[0], now_ms[32:1], zero padding.
    input  logic [lems_pkg::S_DATA_W-1:0]     s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // From bit 0: led_index[2:0], red[10:3], green[18:11], blue[26:19],
    // effect_mode[28:27], zero padding.
    output logic [lems_pkg::M_DATA_W-1:0]     m_tdata,
    output logic                              m_tlast,
    input  logic                              cfg_we,
    input  logic [lems_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [lems_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_CNT  = 7'b0000010,
        S_DEB  = 7'b0000100,
        S_DIFF = 7'b0001000,
        S_CMP  = 7'b0010000,
        S_EMIT = 7'b0100000,
        S_ADV  = 7'b1000000
    } state_t;

    state_t                            state_reg, state_next;
    logic [lems_pkg::CNT_W-1:0]        thr_reg;
    logic [lems_pkg::WAIT_W-1:0]       wait_reg [4];
    logic [lems_pkg::CNT_W-1:0]        press_reg, press_next;
    logic [lems_pkg::CNT_W-1:0]        release_reg, release_next;
    logic                              held_reg, held_next;
    logic [lems_pkg::MODE_W-1:0]       mode_reg, mode_next;
    logic [lems_pkg::TIME_W-1:0]       last_fire_reg [4];
    logic                              btn_reg;
    logic [lems_pkg::TIME_W-1:0]       now_reg;
    logic [lems_pkg::TIME_W-1:0]       diff_reg;
    logic [lems_pkg::IDX_W-1:0]        pix_reg, pix_next;
    logic                              m_valid_reg, m_valid_next;
    logic [lems_pkg::M_DATA_W-1:0]     m_data_reg;
    logic                              m_last_reg;
    logic [lems_pkg::TIME_W-1:0]       alu_a, alu_b, alu_diff;
    logic                              alu_borrow;
    logic                              out_free, load_out, fire;
    lems_pkg::effect_ctrl_t            fx_ctrl;
    lems_pkg::rgb_t                    pixel;

    lems_alu u_alu (
        .op_a   (alu_a),
        .op_b   (alu_b),
        .diff   (alu_diff),
        .borrow (alu_borrow)
    );

    lems_effects u_effects (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (fx_ctrl),
        .pixel   (pixel)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;
    assign out_free = !m_valid_reg || m_tready;
    assign load_out = (state_reg == S_EMIT) && out_free;
    assign fire     = (state_reg == S_CMP) && !alu_borrow;

    assign fx_ctrl.prep    = fire;
    assign fx_ctrl.adv     = (state_reg == S_ADV);
    assign fx_ctrl.mode    = mode_reg;
    assign fx_ctrl.pix_idx = pix_reg;

    always_comb begin
        unique case (state_reg)
            S_DEB: begin
                alu_a = {22'd0, thr_reg};
                alu_b = {22'd0, btn_reg ? press_reg : release_reg};
            end
            S_DIFF: begin
                alu_a = now_reg;
                alu_b = last_fire_reg[mode_reg];
            end
            S_CMP: begin
                alu_a = diff_reg;
                alu_b = {16'd0, wait_reg[mode_reg]};
            end
            default: begin
                alu_a = '0;
                alu_b = '0;
            end
        endcase
    end

    always_comb begin
        state_next   = state_reg;
        press_next   = press_reg;
        release_next = release_reg;
        held_next    = held_reg;
        mode_next    = mode_reg;
        pix_next     = pix_reg;
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_tready) m_valid_next = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) state_next = S_CNT;
            end
            S_CNT: begin
                if (btn_reg) begin
                    if (press_reg < lems_pkg::CNT_MAX) press_next = press_reg + 10'd1;
                    release_next = '0;
                end else begin
                    if (release_reg < lems_pkg::CNT_MAX) release_next = release_reg + 10'd1;
                    press_next = '0;
                end
                state_next = S_DEB;
            end
            S_DEB: begin
                if (alu_borrow) begin
                    if (btn_reg) begin
                        if (!held_reg) begin
                            mode_next = mode_reg + 2'd1;
                            held_next = 1'b1;
                        end
                        press_next = '0;
                    end else begin
                        held_next    = 1'b0;
                        release_next = '0;
                    end
                end
                state_next = S_DIFF;
            end
            S_DIFF: begin
                state_next = S_CMP;
            end
            S_CMP: begin
                pix_next   = '0;
                state_next = alu_borrow ? S_IDLE : S_EMIT;
            end
            S_EMIT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    if (pix_reg == lems_pkg::LAST_LED) begin
                        state_next = S_ADV;
                    end else begin
                        pix_next = pix_reg + 3'd1;
                    end
                end
            end
            S_ADV: begin
                state_next = S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            thr_reg     <= lems_pkg::THR_RESET;
            wait_reg[0] <= lems_pkg::FADE_RESET;
            wait_reg[1] <= lems_pkg::CHASE_RESET;
            wait_reg[2] <= lems_pkg::BREATHE_RESET;
            wait_reg[3] <= lems_pkg::ROTATE_RESET;
            press_reg   <= '0;
            release_reg <= '0;
            held_reg    <= 1'b0;
            mode_reg    <= lems_pkg::MODE_FADE;
            for (int i = 0; i < 4; i++) begin
                last_fire_reg[i] <= '0;
            end
            pix_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            press_reg   <= press_next;
            release_reg <= release_next;
            held_reg    <= held_next;
            mode_reg    <= mode_next;
            pix_reg     <= pix_next;
            m_valid_reg <= m_valid_next;
            if (fire) last_fire_reg[mode_reg] <= now_reg;
            if (cfg_we) begin
                unique case (cfg_addr)
                    lems_pkg::REG_DEBOUNCE: thr_reg     <= cfg_wdata[lems_pkg::CNT_W-1:0];
                    lems_pkg::REG_FADE:     wait_reg[0] <= cfg_wdata;
                    lems_pkg::REG_CHASE:    wait_reg[1] <= cfg_wdata;
                    lems_pkg::REG_BREATHE:  wait_reg[2] <= cfg_wdata;
                    lems_pkg::REG_ROTATE:   wait_reg[3] <= cfg_wdata;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            btn_reg <= s_tdata[0];
            now_reg <= s_tdata[lems_pkg::TIME_W:1];
        end
        if (state_reg == S_DIFF) diff_reg <= alu_diff;
        if (load_out) begin
            m_data_reg <= {3'd0, mode_reg, pixel.blue, pixel.green, pixel.red, pix_reg};
            m_last_reg <= (pix_reg == lems_pkg::LAST_LED);
        end
    end

`ifndef SYNTHESIS
    a_last_on_sixth: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tlast == (m_tdata[2:0] == lems_pkg::LAST_LED)))
        else $error("frame end flag does not match the LED position");

    a_index_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[2:0] <= lems_pkg::LAST_LED))
        else $error("LED position out of range");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("poll accepted while the previous one is in work");

    a_emit_only_on_fire: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_EMIT && !$past(state_reg == S_EMIT)) |-> $past(fire))
        else $error("frame started without a timer firing");
`endif

endmodule

/* src/lems_alu.sv */
// Shared 32-bit subtractor with borrow, used for the debounce and timer compares.
// Depends on lems_pkg.
`timescale 1ns / 1ps

module lems_alu (
    input  logic [lems_pkg::TIME_W-1:0] op_a,
    input  logic [lems_pkg::TIME_W-1:0] op_b,
    output logic [lems_pkg::TIME_W-1:0] diff,
    output logic                        borrow
);

    always_comb begin
        {borrow, diff} = {1'b0, op_a} - {1'b0, op_b};
    end

endmodule

/* src/lems_effects.sv */
// Effect state for fade, chase, breathe and rotate, with the per-LED colour lookup.
// Depends on lems_pkg.
`timescale 1ns / 1ps

module lems_effects (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  lems_pkg::effect_ctrl_t ctrl,
    output lems_pkg::rgb_t        pixel
);

    localparam logic [1:0] PH_B2R = 2'd0;
    localparam logic [1:0] PH_R2G = 2'd1;
    localparam logic [1:0] PH_G2B = 2'd2;

    lems_pkg::rgb_t                  fade_rgb_reg, fade_rgb_next;
    logic [1:0]                      fade_phase_reg, fade_phase_next;
    lems_pkg::rgb_t                  strip_reg [lems_pkg::LED_COUNT];
    logic [lems_pkg::IDX_W-1:0]      chase_pos_reg, chase_pos_next;
    logic [lems_pkg::IDX_W-1:0]      chase_idx_reg, chase_idx_next;
    lems_pkg::rgb_t                  chase_rgb_reg, chase_rgb_next;
    logic [7:0]                      breathe_level_reg, breathe_level_next;
    logic                            breathe_down_reg, breathe_down_next;
    logic [lems_pkg::IDX_W-1:0]      rotate_off_reg, rotate_off_next;
    logic [lems_pkg::IDX_W-1:0]      rot_sel;
    logic [lems_pkg::IDX_W:0]        rot_diff;

    always_comb begin
        lems_pkg::rgb_t c;
        logic [1:0]     ph;
        c  = fade_rgb_reg;
        ph = fade_phase_reg;
        if (ph == PH_B2R) begin
            c.red  = c.red + 8'd1;
            c.blue = c.blue - 8'd1;
            if (c.red == 8'd255 && c.blue == 8'd0) ph = PH_R2G;
        end
        if (ph == PH_R2G) begin
            c.green = c.green + 8'd1;
            c.red   = c.red - 8'd1;
            if (c.green == 8'd255 && c.red == 8'd0) ph = PH_G2B;
        end
        if (ph == PH_G2B) begin
            c.blue  = c.blue + 8'd1;
            c.green = c.green - 8'd1;
            if (c.blue == 8'd255 && c.green == 8'd0) ph = PH_B2R;
        end
        fade_rgb_next   = c;
        fade_phase_next = ph;
    end

    always_comb begin
        logic [lems_pkg::IDX_W-1:0] idx;
        chase_pos_next = chase_pos_reg + 3'd1;
        idx            = chase_idx_reg;
        if (chase_pos_next >= 3'(lems_pkg::LED_COUNT)) begin
            chase_pos_next = '0;
            idx            = idx + 3'd1;
        end
        if (idx >= 3'(lems_pkg::HUES)) idx = '0;
        chase_idx_next = idx;
        chase_rgb_next = lems_pkg::chase_colour(idx);
    end

    always_comb begin
        breathe_level_next = breathe_down_reg ? breathe_level_reg - 8'd1
                                              : breathe_level_reg + 8'd1;
        breathe_down_next  = breathe_down_reg;
        if (breathe_level_next == 8'd255) breathe_down_next = 1'b1;
        if (breathe_level_next == 8'd0)   breathe_down_next = 1'b0;
    end

    always_comb begin
        rotate_off_next = (rotate_off_reg == lems_pkg::LAST_LED) ? '0 : rotate_off_reg + 3'd1;
        rot_diff = {1'b0, ctrl.pix_idx} - {1'b0, rotate_off_reg};
        if (rot_diff[lems_pkg::IDX_W]) begin
            rot_sel = rot_diff[lems_pkg::IDX_W-1:0] + 3'(lems_pkg::HUES);
        end else begin
            rot_sel = rot_diff[lems_pkg::IDX_W-1:0];
        end
    end

    always_comb begin
        unique case (ctrl.mode)
            lems_pkg::MODE_FADE,
            lems_pkg::MODE_CHASE: begin
                pixel = (ctrl.pix_idx <= lems_pkg::LAST_LED) ? strip_reg[ctrl.pix_idx] : '0;
            end
            lems_pkg::MODE_BREATHE: begin
                pixel = '{breathe_level_reg, breathe_level_reg, breathe_level_reg};
            end
            lems_pkg::MODE_ROTATE: begin
                pixel = lems_pkg::rotate_colour(rot_sel);
            end
            default: begin
                pixel = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fade_rgb_reg      <= '{8'd0, 8'd0, 8'd255};
            fade_phase_reg    <= PH_B2R;
            for (int i = 0; i < lems_pkg::LED_COUNT; i++) begin
                strip_reg[i] <= '0;
            end
            chase_pos_reg     <= '0;
            chase_idx_reg     <= '0;
            chase_rgb_reg     <= '0;
            breathe_level_reg <= '0;
            breathe_down_reg  <= 1'b0;
            rotate_off_reg    <= '0;
        end else begin
            if (ctrl.prep) begin
                if (ctrl.mode == lems_pkg::MODE_FADE) begin
                    for (int i = 0; i < lems_pkg::LED_COUNT; i++) begin
                        strip_reg[i] <= fade_rgb_reg;
                    end
                end else if (ctrl.mode == lems_pkg::MODE_CHASE) begin
                    if (chase_pos_reg <= lems_pkg::LAST_LED) begin
                        strip_reg[chase_pos_reg] <= chase_rgb_reg;
                    end
                end
            end
            if (ctrl.adv) begin
                unique case (ctrl.mode)
                    lems_pkg::MODE_FADE: begin
                        fade_rgb_reg   <= fade_rgb_next;
                        fade_phase_reg <= fade_phase_next;
                    end
                    lems_pkg::MODE_CHASE: begin
                        chase_pos_reg <= chase_pos_next;
                        chase_idx_reg <= chase_idx_next;
                        chase_rgb_reg <= chase_rgb_next;
                    end
                    lems_pkg::MODE_BREATHE: begin
                        breathe_level_reg <= breathe_level_next;
                        breathe_down_reg  <= breathe_down_next;
                    end
                    lems_pkg::MODE_ROTATE: begin
                        rotate_off_reg <= rotate_off_next;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

endmodule

/* tb/led_effect_mode_sequencer_test.sv */
// Self-checking testbench for led_effect_mode_sequencer: drives polls, predicts every LED item
// in its own model of debounce, mode timers and the four effects, and compares field by field.
// Depends on lems_pkg and the led_effect_mode_sequencer RTL only.
`timescale 1ns / 1ps

module led_effect_mode_sequencer_test;

    typedef logic [lems_pkg::IDX_W-1:0]      idx_t;
    typedef logic [lems_pkg::MODE_W-1:0]     mode_t;
    typedef logic [lems_pkg::TIME_W-1:0]     ms_t;
    typedef logic [lems_pkg::CFG_ADDR_W-1:0] cfg_addr_t;
    typedef logic [lems_pkg::CFG_DATA_W-1:0] cfg_data_t;

    typedef struct packed {
        idx_t           led;
        lems_pkg::rgb_t colour;
        mode_t          mode;
        logic           last;
    } led_item_t;

    localparam logic [23:0] CHASE_TABLE [lems_pkg::HUES] = '{
        24'h0000FF, 24'h800080, 24'hFF0000, 24'h808000, 24'h00FF00, 24'h008080
    };
    localparam logic [23:0] SPIN_TABLE [lems_pkg::HUES] = '{
        24'h00FF00, 24'hFF0000, 24'h0000FF, 24'h808000, 24'h800080, 24'hFF8000
    };
    localparam int SETTLE_CYCLES = 24;
    localparam int HOLD_CYCLES   = 300;

    logic                                aclk = 1'b0;
    logic                                aresetn = 1'b0;
    logic                                s_tvalid = 1'b0;
    logic                                s_tready;
    logic [lems_pkg::S_DATA_W-1:0]       s_tdata = '0;
    logic                                m_tvalid;
    logic                                m_tready = 1'b0;
    logic [lems_pkg::M_DATA_W-1:0]       m_tdata;
    logic                                m_tlast;
    logic                                cfg_we = 1'b0;
    cfg_addr_t                           cfg_addr = '0;
    cfg_data_t                           cfg_wdata = '0;

    led_item_t expected_leds [$];
    int        mismatch_count = 0;
    int        sender_idle_pct = 0;
    int        receiver_stall_pct = 0;
    logic      hold_start = 1'b0;
    int        hold_left = 0;
    logic      btn_level = 1'b0;
    int        btn_run = 0;

    // Predicted configuration and state of the block.
    logic [lems_pkg::CNT_W-1:0]  debounce_limit;
    logic [lems_pkg::WAIT_W-1:0] step_wait [4];
    logic [lems_pkg::CNT_W-1:0]  press_run, release_run;
    logic                        held;
    mode_t                       cur_mode;
    ms_t                         fired_at [4];
    lems_pkg::rgb_t              fade_colour;
    logic [1:0]                  fade_leg;
    lems_pkg::rgb_t              shared_leds [lems_pkg::LED_COUNT];
    idx_t                        chase_slot, chase_hue;
    lems_pkg::rgb_t              chase_paint;
    logic [7:0]                  glow_level;
    logic                        glow_falling;
    idx_t                        spin_offset;

    led_effect_mode_sequencer u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always #5 aclk = ~aclk;

    task automatic reset_model();
        int i;
        debounce_limit = lems_pkg::THR_RESET;
        step_wait[0] = lems_pkg::FADE_RESET;
        step_wait[1] = lems_pkg::CHASE_RESET;
        step_wait[2] = lems_pkg::BREATHE_RESET;
        step_wait[3] = lems_pkg::ROTATE_RESET;
        press_run = '0;
        release_run = '0;
        held = 1'b0;
        cur_mode = lems_pkg::MODE_FADE;
        for (i = 0; i < 4; i++) fired_at[i] = '0;
        fade_colour = 24'h0000FF;
        fade_leg = 2'd0;
        for (i = 0; i < lems_pkg::LED_COUNT; i++) shared_leds[i] = '0;
        chase_slot = '0;
        chase_hue = '0;
        chase_paint = '0;
        glow_level = '0;
        glow_falling = 1'b0;
        spin_offset = '0;
    endtask

    task automatic step_fade();
        if (fade_leg == 2'd0) begin
            fade_colour.red = fade_colour.red + 8'd1;
            fade_colour.blue = fade_colour.blue - 8'd1;
            if (fade_colour.red == 8'd255 && fade_colour.blue == 8'd0) fade_leg = 2'd1;
        end
        if (fade_leg == 2'd1) begin
            fade_colour.green = fade_colour.green + 8'd1;
            fade_colour.red = fade_colour.red - 8'd1;
            if (fade_colour.green == 8'd255 && fade_colour.red == 8'd0) fade_leg = 2'd2;
        end
        if (fade_leg == 2'd2) begin
            fade_colour.blue = fade_colour.blue + 8'd1;
            fade_colour.green = fade_colour.green - 8'd1;
            if (fade_colour.blue == 8'd255 && fade_colour.green == 8'd0) fade_leg = 2'd0;
        end
    endtask

    task automatic predict_frame(input logic button, input ms_t now);
        ms_t            elapsed;
        lems_pkg::rgb_t led_colour [lems_pkg::LED_COUNT];
        led_item_t      item;
        int             i;
        if (button) begin
            if (press_run != lems_pkg::CNT_MAX) press_run = press_run + 10'd1;
            release_run = '0;
            if (press_run > debounce_limit) begin
                if (!held) begin
                    cur_mode = cur_mode + 2'd1;
                    held = 1'b1;
                end
                press_run = '0;
            end
        end else begin
            if (release_run != lems_pkg::CNT_MAX) release_run = release_run + 10'd1;
            press_run = '0;
            if (release_run > debounce_limit) begin
                held = 1'b0;
                release_run = '0;
            end
        end
        elapsed = now - fired_at[cur_mode];
        if (elapsed < ms_t'(step_wait[cur_mode])) return;
        fired_at[cur_mode] = now;
        case (cur_mode)
            lems_pkg::MODE_FADE: begin
                for (i = 0; i < lems_pkg::LED_COUNT; i++) shared_leds[i] = fade_colour;
                led_colour = shared_leds;
                step_fade();
            end
            lems_pkg::MODE_CHASE: begin
                shared_leds[chase_slot % 3'd6] = chase_paint;
                led_colour = shared_leds;
                chase_slot = chase_slot % 3'd6 + 3'd1;
                if (chase_slot >= 3'd6) begin
                    chase_slot = '0;
                    chase_hue = chase_hue + 3'd1;
                end
                if (chase_hue >= 3'd6) chase_hue = '0;
                chase_paint = CHASE_TABLE[chase_hue];
            end
            lems_pkg::MODE_BREATHE: begin
                for (i = 0; i < lems_pkg::LED_COUNT; i++) led_colour[i] = {3{glow_level}};
                if (glow_falling) glow_level = glow_level - 8'd1;
                else glow_level = glow_level + 8'd1;
                if (glow_level == 8'd255) glow_falling = 1'b1;
                if (glow_level == 8'd0) glow_falling = 1'b0;
            end
            default: begin
                spin_offset = spin_offset % 3'd6;
                for (i = 0; i < lems_pkg::LED_COUNT; i++) begin
                    led_colour[i] = SPIN_TABLE[idx_t'((i + lems_pkg::HUES - int'(spin_offset))
                                                      % lems_pkg::HUES)];
                end
                spin_offset = (spin_offset + 3'd1) % 3'd6;
            end
        endcase
        for (i = 0; i < lems_pkg::LED_COUNT; i++) begin
            item.led = idx_t'(i);
            item.colour = led_colour[i];
            item.mode = cur_mode;
            item.last = (i == lems_pkg::LED_COUNT - 1);
            expected_leds.push_back(item);
        end
    endtask

    task automatic check_field(input string field, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge aclk) begin : check_leds
        led_item_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_leds.size() == 0) begin
                $error("LED item with no expectation waiting: tdata %h", m_tdata);
                mismatch_count++;
            end else begin
                want = expected_leds.pop_front();
                check_field("led_index", want.led, m_tdata[2:0]);
                check_field("red", want.colour.red, m_tdata[10:3]);
                check_field("green", want.colour.green, m_tdata[18:11]);
                check_field("blue", want.colour.blue, m_tdata[26:19]);
                check_field("effect_mode", want.mode, m_tdata[28:27]);
                check_field("frame_last", want.last, m_tlast);
            end
        end
    end

    always @(posedge aclk) begin
        if (hold_start) begin
            hold_left <= HOLD_CYCLES - 1;
            m_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    task automatic write_reg(input cfg_addr_t addr, input cfg_data_t data);
        cfg_we <= 1'b1;
        cfg_addr <= addr;
        cfg_wdata <= data;
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
        if (addr == lems_pkg::REG_DEBOUNCE) debounce_limit = data[lems_pkg::CNT_W-1:0];
        else if (addr <= lems_pkg::REG_ROTATE) step_wait[2'(addr - lems_pkg::REG_FADE)] = data;
    endtask

    task automatic write_all(input cfg_data_t limit, input logic [lems_pkg::WAIT_W-1:0] waits);
        int k;
        write_reg(lems_pkg::REG_DEBOUNCE, limit);
        for (k = 0; k < 4; k++) write_reg(lems_pkg::REG_FADE + cfg_addr_t'(k), waits);
    endtask

    task automatic send_poll(input logic button, input ms_t now);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {7'd0, now, button};
        do @(posedge aclk); while (!s_tready);
        predict_frame(button, now);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (expected_leds.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Needs a debounce limit of zero, so that each press is accepted at once.
    task automatic goto_mode(input mode_t target, input ms_t now);
        while (cur_mode != target) begin
            send_poll(1'b1, now);
            send_poll(1'b0, now);
        end
    endtask

    function automatic logic next_button();
        if (btn_run == 0) begin
            btn_level = ~btn_level;
            if ($urandom_range(4) != 0) btn_run = int'(debounce_limit) + 1 + $urandom_range(2);
            else btn_run = $urandom_range(1, int'(debounce_limit) + 1);
        end
        btn_run--;
        if ($urandom_range(19) == 0) return ~btn_level;
        return btn_level;
    endfunction

    task automatic test_reset_defaults();
        send_poll(1'b0, 32'd0);
        send_poll(1'b0, 32'd5);
        send_poll(1'b0, 32'd10);
        send_poll(1'b0, 32'd19);
        send_poll(1'b0, 32'd20);
    endtask

    task automatic test_register_writes();
        ms_t now;
        int  k;
        drain_results();
        for (k = 1; k < 4; k++) begin
            write_reg(lems_pkg::REG_ROTATE + cfg_addr_t'(k), cfg_data_t'($urandom_range(65535)));
        end
        // Upper bits of the debounce limit are dropped, leaving zero.
        write_reg(lems_pkg::REG_DEBOUNCE, 16'hFC00);
        write_reg(lems_pkg::REG_FADE, 16'd0);
        write_reg(lems_pkg::REG_CHASE, 16'hFFFF);
        write_reg(lems_pkg::REG_BREATHE, 16'd1);
        write_reg(lems_pkg::REG_ROTATE, 16'hFFFF);
        now = $urandom;
        for (k = 0; k < 10; k++) begin
            send_poll(k % 2 == 0, now);
            now = now + 32'd1;
        end
    endtask

    task automatic test_mode_cycle();
        int k;
        drain_results();
        write_all(16'd0, 16'd0);
        for (k = 0; k < 16; k++) send_poll(k % 2 == 0, $urandom);
    endtask

    task automatic test_timer_wrap();
        ms_t base;
        drain_results();
        base = 32'hFFFF_FFF0;
        write_all(16'd0, 16'd0);
        goto_mode(lems_pkg::MODE_FADE, base);
        send_poll(1'b0, base);
        drain_results();
        write_reg(lems_pkg::REG_FADE, 16'hFFFF);
        send_poll(1'b0, base + 32'd65534);
        send_poll(1'b0, base + 32'd65535);
        send_poll(1'b0, 32'hFFFF_FFFF);
        send_poll(1'b0, 32'hFFFF_FFFF);
    endtask

    task automatic test_high_threshold();
        ms_t base;
        int  k;
        drain_results();
        write_all(16'h03FF, 16'hFFFF);
        base = $urandom;
        for (k = 0; k < 24; k++) send_poll(1'b1, base);
        send_poll(1'b1, base + 32'd65535);
        for (k = 0; k < 4; k++) send_poll(1'b0, base + 32'd65535);
        drain_results();
        write_reg(lems_pkg::REG_DEBOUNCE, 16'd1);
        for (k = 0; k < 8; k++) send_poll(k % 4 < 2, base + 32'd70000 + ms_t'(k) * 32'd65535);
    endtask

    task automatic test_backpressure();
        int k;
        drain_results();
        write_all(16'd0, 16'd0);
        hold_start <= 1'b1;
        @(posedge aclk);
        hold_start <= 1'b0;
        for (k = 0; k < 12; k++) send_poll(k % 3 == 0, $urandom);
        drain_results();
    endtask

    task automatic test_effect_soak(input mode_t mode, input int count);
        int k;
        drain_results();
        write_all(16'd0, 16'd0);
        goto_mode(mode, $urandom);
        for (k = 0; k < count; k++) send_poll(1'b0, $urandom);
    endtask

    task automatic test_random_phase(input int idle_pct, input int stall_pct, input int count);
        ms_t now;
        int  k;
        drain_results();
        write_reg(lems_pkg::REG_DEBOUNCE, cfg_data_t'($urandom_range(5)));
        for (k = 0; k < 4; k++) begin
            write_reg(lems_pkg::REG_FADE + cfg_addr_t'(k), ($urandom_range(3) == 0) ?
                      cfg_data_t'($urandom_range(65535)) : cfg_data_t'($urandom_range(20)));
        end
        sender_idle_pct = idle_pct;
        receiver_stall_pct <= stall_pct;
        now = $urandom;
        for (k = 0; k < count; k++) begin
            if ($urandom_range(19) == 0) now = $urandom;
            else now = now + ms_t'($urandom_range(12));
            send_poll(next_button(), now);
        end
    endtask

    initial begin
        reset_model();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_defaults();
        test_register_writes();
        test_mode_cycle();
        test_timer_wrap();
        test_high_threshold();
        test_backpressure();
        test_effect_soak(lems_pkg::MODE_CHASE, 40);
        test_effect_soak(lems_pkg::MODE_FADE, 60);
        test_effect_soak(lems_pkg::MODE_BREATHE, 60);
        test_effect_soak(lems_pkg::MODE_ROTATE, 8);
        test_random_phase(0, 0, 45);
        test_random_phase(64, 0, 45);
        test_random_phase(0, 64, 45);
        test_random_phase(36, 36, 45);
        drain_results();
        if (mismatch_count == 0 && expected_leds.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
